// ----- rtl/edq_pkg.sv -----
// Shared constants, codes and control structs for the event dispatch queue.
package edq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_SIGNAL      = 63;
  localparam int IDLE_STEP       = 5;

  localparam int CMD_W      = 2;
  localparam int SIG_W      = 8;
  localparam int SIG_OUT_W  = 6;
  localparam int STATUS_W   = 3;
  localparam int IDLE_W     = 32;
  localparam int MASK_W     = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic take_in;
    logic do_emit;
    logic do_tick_empty;
    logic do_clear;
    logic fetch;
    logic load_pop;
  } edq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             occ_zero;
    logic             out_free;
    logic             pop_last;
  } edq_stat_t;

endpackage

// ----- rtl/edq_ctrl.sv -----
// Controller state machine: sequences accept, execute and drain of each request.
module edq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  edq_pkg::edq_stat_t  stat,
  output edq_pkg::edq_cmd_t   cmd
);
  import edq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  state_t state, state_next;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
          unique case (stat.cmd)
            CMD_EMIT:  cmd.do_emit = 1'b1;
            CMD_TICK: begin
              if (stat.occ_zero) begin
                cmd.do_tick_empty = 1'b1;
              end else begin
                cmd.fetch  = 1'b1;
                state_next = S_DRAIN;
              end
            end
            CMD_CLEAR: cmd.do_clear = 1'b1;
            default:   state_next = S_IDLE;  // unused code: no result
          endcase
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.load_pop = 1'b1;
          if (stat.pop_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.fetch = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/edq_datapath.sv -----
// Datapath: request register, handler mask, event FIFO, idle counter, result register.
module edq_datapath #(
  parameter int QUEUE_DEPTH = edq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [edq_pkg::CMD_W-1:0]       in_cmd,
  input  logic [edq_pkg::SIG_W-1:0]       in_sig,
  input  logic                            cfg_wr_en,
  input  logic [edq_pkg::MASK_W-1:0]      cfg_wr_data,
  input  edq_pkg::edq_cmd_t               cmd,
  output edq_pkg::edq_stat_t              stat,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [edq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [edq_pkg::STATUS_W-1:0]    m_axis_tuser,
  output logic                            m_axis_tlast
);
  import edq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

  logic [CMD_W-1:0]     req_cmd;
  logic [SIG_W-1:0]     req_sig;
  logic [MASK_W-1:0]    mask;
  logic [SIG_OUT_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     rptr, wptr;
  logic [OCC_W-1:0]     occ;
  logic [IDLE_W-1:0]    idle;
  logic [SIG_OUT_W-1:0] rd_sig;
  logic                 rd_last;

  logic [SIG_OUT_W-1:0] out_sig;
  logic                 out_delivered;
  logic [IDLE_W-1:0]    out_idle;

  logic [STATUS_W-1:0]  emit_status;
  logic [IDLE_W:0]      idle_sum;
  logic [IDLE_W-1:0]    idle_sat;
  logic                 out_load;

  always_comb begin
    priority if (req_sig > SIG_W'(MAX_SIGNAL)) begin
      emit_status = ST_RANGE;
    end else if (!mask[req_sig[SIG_OUT_W-1:0]]) begin
      emit_status = ST_NO_HANDLER;
    end else if (occ == OCC_FULL) begin
      emit_status = ST_FULL;
    end else begin
      emit_status = ST_OK;
    end
  end

  assign idle_sum = {1'b0, idle} + (IDLE_W + 1)'(IDLE_STEP);
  assign idle_sat = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];

  assign out_load = cmd.do_emit | cmd.do_tick_empty | cmd.do_clear | cmd.load_pop;

  assign stat.cmd      = req_cmd;
  assign stat.occ_zero = (occ == '0);
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;
  assign stat.pop_last = rd_last;

  assign m_axis_tdata = {1'b0, out_idle, out_delivered, out_sig};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mask          <= '0;
      rptr          <= '0;
      wptr          <= '0;
      occ           <= '0;
      idle          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask <= cfg_wr_data;
      end
      if (cmd.do_emit && emit_status == ST_OK) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
        occ  <= occ + 1'b1;
      end
      if (cmd.fetch) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
        occ  <= occ - 1'b1;
      end
      if (cmd.do_tick_empty) begin
        idle <= idle_sat;
      end
      if (cmd.do_clear || (cmd.load_pop && rd_last)) begin
        idle <= '0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req_cmd <= in_cmd;
      req_sig <= in_sig;
    end
    if (cmd.do_emit && emit_status == ST_OK) begin
      mem[wptr] <= req_sig[SIG_OUT_W-1:0];
    end
    if (cmd.fetch) begin
      rd_sig  <= mem[rptr];
      rd_last <= (occ == OCC_ONE);
    end
    if (out_load) begin
      priority if (cmd.load_pop) begin
        out_sig       <= rd_sig;
        out_delivered <= mask[rd_sig];
        m_axis_tlast  <= rd_last;
        out_idle      <= '0;
        m_axis_tuser  <= ST_OK;
      end else begin
        out_sig       <= '0;
        out_delivered <= 1'b0;
        m_axis_tlast  <= 1'b1;
        priority if (cmd.do_emit) begin
          m_axis_tuser <= emit_status;
          out_idle     <= idle;
        end else if (cmd.do_tick_empty) begin
          m_axis_tuser <= ST_EMPTY;
          out_idle     <= idle_sat;
        end else begin
          m_axis_tuser <= ST_OK;
          out_idle     <= '0;
        end
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= OCC_FULL)
    else $error("occupancy above queue depth");
  a_fetch_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> occ != '0)
    else $error("fetch from empty queue");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while held");
  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_pop && rd_last) |-> occ == '0)
    else $error("last pop with events still queued");

endmodule

// ----- rtl/event_dispatch_queue_core.sv -----
// Top level of the event dispatch queue: controller plus datapath.
// Requests enter on s_axis: tuser carries the command (0 emit, 1 tick, 2 clear
// idle time), tdata the signal number. Results leave on m_axis, one per request,
// except a tick on a non-empty queue, which gives one result per queued event
// in FIFO order with tlast on the final one; tlast is set on every result of the other requests.
// handler_mask is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while no request is in flight, as the block does not enforce this. Bit s
// enables signal s. A request is taken into the request register, and its result
// is then loaded into the result register once that register is free; an emit,
// clear or empty tick gives its single result that way. A drain first reads the
// head of the event FIFO, then delivers one event per cycle while m_axis_tready
// stays high. The single read port of the event FIFO sets the drain pace. Command
// code 3 is dropped with no result. Reset (rst, synchronous) empties the queue,
// clears the idle counter and the handler mask, and drops any pending result.
// When the receiver stalls, the result register holds; one more request can be
// taken, and it waits in the request register until the held result drains.
module event_dispatch_queue_core #(
  parameter int QUEUE_DEPTH = edq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [edq_pkg::SIG_W-1:0]       s_axis_tdata,   // [7:0] sig
  input  logic [edq_pkg::CMD_W-1:0]       s_axis_tuser,   // [1:0] cmd
  input  logic                            cfg_wr_en,
  input  logic [edq_pkg::MASK_W-1:0]      cfg_wr_data,    // handler_mask
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [edq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [5:0] sig_out, [6] delivered,
                                                          // [38:7] idle_time, [39] zero
  output logic [edq_pkg::STATUS_W-1:0]    m_axis_tuser,   // [2:0] status
  output logic                            m_axis_tlast
);
  import edq_pkg::*;

  edq_cmd_t  cmd;
  edq_stat_t stat;

  edq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  edq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_cmd        (s_axis_tuser),
    .in_sig        (s_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for event_dispatch_queue_core: emit/tick/clear requests vs. a queue model.
module tb_top;
  import edq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;  // undefined code, dropped by the block

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SIG_OUT_W-1:0] sig_out;
    logic                 delivered;
    logic                 last;
    logic [IDLE_W-1:0]    idle;
  } edq_result_t;

  typedef struct {
    bit                  is_cfg;
    logic [CMD_W-1:0]    cmd;
    logic [SIG_W-1:0]    sig;
    logic [MASK_W-1:0]   mask;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [IDLE_W-1:0]   idle;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic [SIG_W-1:0]      s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  cfg_wr_en = 1'b0;
  logic [MASK_W-1:0]     cfg_wr_data = '0;
  logic                  m_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  // queue model state
  logic [SIG_OUT_W-1:0] model_fifo[$];
  logic [IDLE_W-1:0]    model_idle = '0;
  logic [MASK_W-1:0]    model_mask = '0;

  edq_result_t due_results[$];
  stim_row_t   stim_rows[$];
  int          err_count = 0;
  int          hold_len = 0;
  bit          no_idle = 1'b0;

  event_dispatch_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Expected results for one accepted request.
  function automatic void dispatch_model(input logic [CMD_W-1:0] cmd,
                                         input logic [SIG_W-1:0] sig);
    edq_result_t r;
    logic [SIG_OUT_W-1:0] s;
    r = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_EMIT: begin
        if (sig > MAX_SIGNAL) r.status = ST_RANGE;
        else if (!model_mask[sig[5:0]]) r.status = ST_NO_HANDLER;
        else if (model_fifo.size() >= QUEUE_DEPTH_DEF) r.status = ST_FULL;
        else begin
          model_fifo.push_back(sig[5:0]);
          r.status = ST_OK;
        end
        r.idle = model_idle;
        due_results.push_back(r);
      end
      CMD_TICK: begin
        if (model_fifo.size() == 0) begin
          if (model_idle > 32'hFFFF_FFFF - IDLE_STEP) model_idle = '1;
          else model_idle = model_idle + IDLE_STEP;
          r.status = ST_EMPTY;
          r.idle = model_idle;
          due_results.push_back(r);
        end else begin
          // drain: mask is sampled once for the whole pass
          while (model_fifo.size() > 0) begin
            s = model_fifo.pop_front();
            r.status = ST_OK;
            r.sig_out = s;
            r.delivered = model_mask[s];
            r.last = (model_fifo.size() == 0);
            r.idle = '0;
            due_results.push_back(r);
          end
          model_idle = '0;
        end
      end
      CMD_CLEAR: begin
        model_idle = '0;
        r.status = ST_OK;
        due_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    edq_result_t want;
    if (!rst && m_axis_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result with no request pending: status %0d tdata %h",
               m_axis_tuser, m_axis_tdata);
        err_count++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        check_field("sig_out", 64'(want.sig_out), 64'(m_axis_tdata[5:0]));
        check_field("delivered", 64'(want.delivered), 64'(m_axis_tdata[6]));
        check_field("idle_time", 64'(want.idle), 64'(m_axis_tdata[38:7]));
        check_field("pad", 64'd0, 64'(m_axis_tdata[39]));
        check_field("last", 64'(want.last), 64'(m_axis_tlast));
      end
    end
  end

  // Receiver: random stall per result, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SIG_W-1:0] sig);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sig;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    dispatch_model(cmd, sig);
  endtask

  // Mask writes only with the block idle; the pause covers a dropped code-3 request.
  task automatic write_mask(input logic [MASK_W-1:0] v);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    model_mask = v;
  endtask

  task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [SIG_W-1:0] sig,
                         input bit typed, input logic [STATUS_W-1:0] status,
                         input logic [IDLE_W-1:0] idle);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cmd: cmd, sig: sig, mask: '0, typed: typed,
            status: status, idle: idle};
    stim_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [MASK_W-1:0] mask);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cmd: CMD_NOP, sig: '0, mask: mask, typed: 1'b0,
            status: ST_OK, idle: '0};
    stim_rows.push_back(row);
  endtask

  initial begin : stimulus
    stim_row_t        row;
    edq_result_t      typed_res;
    logic [CMD_W-1:0] cmd;
    logic [SIG_W-1:0] sig;
    logic [MASK_W-1:0] mask;
    int phase, n, k, pick, tick_pct;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    add_req(CMD_TICK, 8'h00, 1, ST_EMPTY, 5);
    add_req(CMD_TICK, 8'hFF, 1, ST_EMPTY, 10);
    add_req(CMD_CLEAR, 8'hAA, 1, ST_OK, 0);
    add_req(CMD_EMIT, 8'd0, 1, ST_NO_HANDLER, 0);
    add_req(CMD_EMIT, 8'd64, 1, ST_RANGE, 0);
    add_req(CMD_EMIT, 8'd255, 1, ST_RANGE, 0);
    add_req(CMD_NOP, 8'h55, 0, ST_OK, 0);
    add_cfg('1);
    add_req(CMD_EMIT, 8'd0, 1, ST_OK, 0);
    add_req(CMD_EMIT, 8'd63, 1, ST_OK, 0);
    for (k = 1; k <= 14; k++) add_req(CMD_EMIT, k[7:0], 0, ST_OK, 0);
    add_req(CMD_EMIT, 8'd7, 1, ST_FULL, 0);
    // half the queued signals lose their handler before the drain
    add_cfg(64'h5555_5555_5555_5555);
    add_req(CMD_TICK, 8'h00, 0, ST_OK, 0);
    add_req(CMD_TICK, 8'h00, 1, ST_EMPTY, 5);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) write_mask(row.mask);
      else begin
        offer(row.cmd, row.sig);
        if (row.typed) begin
          typed_res = '{status: row.status, sig_out: '0, delivered: 1'b0,
                        last: 1'b1, idle: row.idle};
          due_results[due_results.size() - 1] = typed_res;
        end
      end
    end

    // random part
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 5)
        0: mask = '1;
        1: mask = {$urandom, $urandom};
        2: mask = '0;
        3: mask = {$urandom, $urandom} & {$urandom, $urandom};
        default: mask = ~({$urandom, $urandom} & {$urandom, $urandom});
      endcase
      write_mask(mask);
      no_idle = (phase == 4 || phase == 9);
      case ($urandom_range(0, 2))
        0: tick_pct = 4;
        1: tick_pct = 12;
        default: tick_pct = 30;
      endcase
      if (phase == 0) begin
        tick_pct = 4;
        hold_len = 200;  // receiver stops long enough for the queue and input to back up
      end
      for (n = 0; n < 28; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < tick_pct) cmd = CMD_TICK;
        else if (pick < tick_pct + 5) cmd = CMD_CLEAR;
        else if (pick < tick_pct + 8) cmd = CMD_NOP;
        else cmd = CMD_EMIT;
        if (cmd == CMD_EMIT && $urandom_range(0, 99) >= 8) begin
          // prefer signals with a handler so the queue actually fills
          sig = SIG_W'($urandom_range(0, 63));
          for (k = 0; k < 3 && !model_mask[sig[5:0]]; k++) begin
            sig = SIG_W'($urandom_range(0, 63));
          end
        end else if (cmd == CMD_EMIT) begin
          sig = SIG_W'($urandom_range(64, 255));
        end else begin
          sig = SIG_W'($urandom_range(0, 255));
        end
        offer(cmd, sig);
      end
    end
    // final drain so nothing stays queued
    offer(CMD_TICK, 8'h00);
    s_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
